/* design/bpc_pkg.sv */
// Package for the brush stroke canvas painter.
// Holds the shared widths, request codes, state type and stroke command.
// Depends on nothing.
`default_nettype none

package bpc_pkg;

   localparam int DEF_CANVAS_WIDTH  = 96;
   localparam int DEF_CANVAS_HEIGHT = 72;
   localparam int DEF_PIXEL_BITS    = 32;

   localparam int COORD_W  = 11;
   localparam int TYPE_W   = 3;
   localparam int RADDR_W  = 13;
   localparam int VALUE_W  = 32;
   localparam int DIM_W    = 10;
   localparam int LIN_W    = 21;

   localparam logic signed [COORD_W-1:0] NO_POINT = -11'sd1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_DOWN = 3'd0,
      REQ_MOVE = 3'd1,
      REQ_UP   = 3'd2,
      REQ_HOLD = 3'd3,
      REQ_READ = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STROKE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
   } stroke_cmd_type;

endpackage

`default_nettype wire

/* design/bpc_canvas_mem.sv */
// Canvas pixel memory: one write port and one registered read port.
// Standalone; no package needed.
`default_nettype none

module bpc_canvas_mem #(
   parameter int DEPTH  = 6912,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/bpc_stroke.sv */
// Stroke walker: steps from one point to another and emits the clipped
// pixel writes of a 3x3 brush at every step point. Uses bpc_pkg.
`default_nettype none

module bpc_stroke #(
   parameter int CANVAS_WIDTH  = bpc_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = bpc_pkg::DEF_CANVAS_HEIGHT,
   parameter int ADDR_W        = 13
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   go,
   input  wire bpc_pkg::stroke_cmd_type cmd,
   output logic                        done,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr
);

   localparam int CW   = bpc_pkg::COORD_W;
   localparam int XW   = CW + 1;
   localparam int LW   = bpc_pkg::LIN_W;
   localparam int DW   = bpc_pkg::DIM_W;
   localparam logic [1:0] OFF_LAST = 2'd2;

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic                 wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0]    wr_addr_ff, wr_addr_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CW-1:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic [CW-1:0]        adx_ff, adx_in, ady_ff, ady_in;
   logic [CW-1:0]        steps_ff, steps_in, left_ff, left_in;
   logic                 sgx_ff, sgx_in, sgy_ff, sgy_in;
   logic [1:0]           ox_ff, ox_in, oy_ff, oy_in;

   logic [XW-1:0] dx, dy, neg_dx, neg_dy;
   logic [CW-1:0] adx, ady;
   logic [XW-1:0] px, py;
   logic          in_x, in_y;
   logic [LW-1:0] lin;
   logic [XW-1:0] sum_x, sum_y, sub_x, sub_y;

   always_comb begin
      dx     = {cmd.x1[CW-1], cmd.x1} - {cmd.x0[CW-1], cmd.x0};
      dy     = {cmd.y1[CW-1], cmd.y1} - {cmd.y0[CW-1], cmd.y0};
      neg_dx = -dx;
      neg_dy = -dy;
      adx    = dx[XW-1] ? neg_dx[CW-1:0] : dx[CW-1:0];
      ady    = dy[XW-1] ? neg_dy[CW-1:0] : dy[CW-1:0];

      px   = {cx_ff[CW-1], cx_ff} + XW'(ox_ff) - XW'(1);
      py   = {cy_ff[CW-1], cy_ff} + XW'(oy_ff) - XW'(1);
      in_x = !px[XW-1] && (px < XW'(CANVAS_WIDTH));
      in_y = !py[XW-1] && (py < XW'(CANVAS_HEIGHT));
      lin  = LW'(py[DW-1:0]) * LW'(CANVAS_WIDTH) + LW'(px[DW-1:0]);

      sum_x = {1'b0, rx_ff} + {1'b0, adx_ff};
      sum_y = {1'b0, ry_ff} + {1'b0, ady_ff};
      sub_x = sum_x - {1'b0, steps_ff};
      sub_y = sum_y - {1'b0, steps_ff};
   end

   always_comb begin
      active_in  = active_ff;
      done_in    = 1'b0;
      wr_en_in   = 1'b0;
      wr_addr_in = lin[ADDR_W-1:0];
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      adx_in     = adx_ff;
      ady_in     = ady_ff;
      steps_in   = steps_ff;
      left_in    = left_ff;
      sgx_in     = sgx_ff;
      sgy_in     = sgy_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      if (go && !active_ff) begin
         active_in = 1'b1;
         cx_in     = cmd.x0;
         cy_in     = cmd.y0;
         rx_in     = '0;
         ry_in     = '0;
         adx_in    = adx;
         ady_in    = ady;
         steps_in  = (adx > ady) ? adx : ady;
         left_in   = (adx > ady) ? adx : ady;
         sgx_in    = dx[XW-1];
         sgy_in    = dy[XW-1];
         ox_in     = '0;
         oy_in     = '0;
      end else if (active_ff) begin
         wr_en_in = in_x && in_y;
         if (ox_ff == OFF_LAST) begin
            ox_in = '0;
            if (oy_ff == OFF_LAST) begin
               oy_in = '0;
               if (left_ff == '0) begin
                  active_in = 1'b0;
                  done_in   = 1'b1;
               end else begin
                  left_in = left_ff - 1'b1;
                  if (sum_x >= {1'b0, steps_ff}) begin
                     rx_in = sub_x[CW-1:0];
                     cx_in = sgx_ff ? cx_ff - 11'sd1 : cx_ff + 11'sd1;
                  end else begin
                     rx_in = sum_x[CW-1:0];
                  end
                  if (sum_y >= {1'b0, steps_ff}) begin
                     ry_in = sub_y[CW-1:0];
                     cy_in = sgy_ff ? cy_ff - 11'sd1 : cy_ff + 11'sd1;
                  end else begin
                     ry_in = sum_y[CW-1:0];
                  end
               end
            end else begin
               oy_in = oy_ff + 1'b1;
            end
         end else begin
            ox_in = ox_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         wr_en_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         wr_en_ff  <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      adx_ff     <= adx_in;
      ady_ff     <= ady_in;
      steps_ff   <= steps_in;
      left_ff    <= left_in;
      sgx_ff     <= sgx_in;
      sgy_ff     <= sgy_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
   end

   assign done    = done_ff;
   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;

endmodule

`default_nettype wire

/* design/brush_stroke_canvas_painter.sv */
// After reset the block clears the canvas memory, one pixel per cycle, and
// holds busy high until the last pixel has been cleared.
// Every accepted transaction then gives exactly one result, shown on the rsp_
// ports for a single cycle with rsp_strobe; the receiver cannot stall it.
// An up request, an unused code or a read outside the canvas answers in the
// next cycle, and a read inside the canvas after the memory's registered read
// and the response register. Down and hold stamp one 3x3 brush and a move
// stamps max(|dx|,|dy|)+1 brushes; each brush writes its nine pixels one at a
// time, because the canvas memory has a single write port. Top level; uses
// bpc_pkg, bpc_stroke and bpc_canvas_mem.
`default_nettype none

module brush_stroke_canvas_painter #(
   parameter int CANVAS_WIDTH  = bpc_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = bpc_pkg::DEF_CANVAS_HEIGHT,
   parameter int PIXEL_BITS    = bpc_pkg::DEF_PIXEL_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [bpc_pkg::TYPE_W-1:0]          req_type,
   input  wire logic signed [bpc_pkg::COORD_W-1:0]  req_pos_x,
   input  wire logic signed [bpc_pkg::COORD_W-1:0]  req_pos_y,
   input  wire logic [bpc_pkg::RADDR_W-1:0]         req_read_addr,
   output logic                                     rsp_strobe,
   output logic [bpc_pkg::VALUE_W-1:0]              rsp_read_value,
   output logic                                     rsp_was_read,
   input  wire logic                                csr_wr_en,
   input  wire logic [bpc_pkg::VALUE_W-1:0]         csr_wr_data
);

   localparam int PIX_COUNT = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int ADDR_W    = $clog2(PIX_COUNT);
   localparam int CW        = bpc_pkg::COORD_W;
   localparam int LW        = bpc_pkg::LIN_W;
   localparam int VW        = bpc_pkg::VALUE_W;
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PIX_COUNT - 1);

   bpc_pkg::state_type   state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic signed [CW-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [PIXEL_BITS-1:0] ink_ff;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic                 rsp_was_read_ff, rsp_was_read_in;

   bpc_pkg::stroke_cmd_type cmd;
   logic                  go;
   logic                  walk_done, walk_wr_en;
   logic [ADDR_W-1:0]     walk_wr_addr;
   logic                  mem_wr_en, rd_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [PIXEL_BITS-1:0] mem_wr_data, rd_data;
   logic [LW-1:0]         raddr_ext;
   logic                  read_ok;

   assign raddr_ext = LW'(req_read_addr);
   assign read_ok   = raddr_ext < LW'(PIX_COUNT);

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      go              = 1'b0;
      cmd.x0          = req_pos_x;
      cmd.y0          = req_pos_y;
      cmd.x1          = req_pos_x;
      cmd.y1          = req_pos_y;
      rd_en           = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_value_in    = '0;
      rsp_was_read_in = 1'b0;
      case (state_ff)
         bpc_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = bpc_pkg::ST_IDLE;
            end
         end
         bpc_pkg::ST_IDLE: begin
            if (start) begin
               case (req_type)
                  bpc_pkg::REQ_DOWN: begin
                     go        = 1'b1;
                     last_x_in = req_pos_x;
                     last_y_in = req_pos_y;
                     state_in  = bpc_pkg::ST_STROKE;
                  end
                  bpc_pkg::REQ_MOVE: begin
                     go        = 1'b1;
                     cmd.x0    = last_x_ff;
                     cmd.y0    = last_y_ff;
                     last_x_in = req_pos_x;
                     last_y_in = req_pos_y;
                     state_in  = bpc_pkg::ST_STROKE;
                  end
                  bpc_pkg::REQ_UP: begin
                     last_x_in     = bpc_pkg::NO_POINT;
                     last_y_in     = bpc_pkg::NO_POINT;
                     rsp_strobe_in = 1'b1;
                  end
                  bpc_pkg::REQ_HOLD: begin
                     go       = 1'b1;
                     state_in = bpc_pkg::ST_STROKE;
                  end
                  bpc_pkg::REQ_READ: begin
                     if (read_ok) begin
                        rd_en    = 1'b1;
                        state_in = bpc_pkg::ST_READ;
                     end else begin
                        rsp_strobe_in   = 1'b1;
                        rsp_was_read_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         bpc_pkg::ST_STROKE: begin
            if (walk_done) begin
               rsp_strobe_in = 1'b1;
               state_in      = bpc_pkg::ST_IDLE;
            end
         end
         bpc_pkg::ST_READ: begin
            rsp_strobe_in   = 1'b1;
            rsp_was_read_in = 1'b1;
            rsp_value_in    = VW'(rd_data);
            state_in        = bpc_pkg::ST_IDLE;
         end
         default: begin
            state_in = bpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         last_x_ff     <= bpc_pkg::NO_POINT;
         last_y_ff     <= bpc_pkg::NO_POINT;
         ink_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            ink_ff <= csr_wr_data[PIXEL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff    <= rsp_value_in;
      rsp_was_read_ff <= rsp_was_read_in;
   end

   assign mem_wr_en   = (state_ff == bpc_pkg::ST_CLEAR) || walk_wr_en;
   assign mem_wr_addr = (state_ff == bpc_pkg::ST_CLEAR) ? clr_ff : walk_wr_addr;
   assign mem_wr_data = (state_ff == bpc_pkg::ST_CLEAR) ? '0 : ink_ff;

   bpc_stroke #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .ADDR_W        (ADDR_W)
   ) u_stroke (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .cmd     (cmd),
      .done    (walk_done),
      .wr_en   (walk_wr_en),
      .wr_addr (walk_wr_addr)
   );

   bpc_canvas_mem #(
      .DEPTH  (PIX_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (PIXEL_BITS)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (raddr_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign busy           = (state_ff != bpc_pkg::ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_was_read   = rsp_was_read_ff;

endmodule

`default_nettype wire

/* design/bpc_checker.sv */
// Port-level checks for the brush stroke canvas painter, bound to its top
// level below. Uses bpc_pkg for the request codes.
`default_nettype none

module bpc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [bpc_pkg::TYPE_W-1:0]     req_type,
   input wire logic                           rsp_strobe,
   input wire logic [bpc_pkg::VALUE_W-1:0]    rsp_read_value,
   input wire logic                           rsp_was_read
);

   // The canvas clearing pass always follows reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy not raised after reset");

   // A result only ever follows an accepted transaction or busy work.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a transaction");

   // Only a read carries a pixel value.
   a_zero_unless_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_was_read) |-> (rsp_read_value == '0))
      else $error("non-read result carries a value");

   // An up request answers in the very next cycle and leaves the block idle.
   a_up_answers_at_once: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == bpc_pkg::REQ_UP)) |=>
         (rsp_strobe && !rsp_was_read && !busy))
      else $error("up transaction not answered at once");

endmodule

bind brush_stroke_canvas_painter bpc_checker u_bpc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_type       (req_type),
   .rsp_strobe     (rsp_strobe),
   .rsp_read_value (rsp_read_value),
   .rsp_was_read   (rsp_was_read)
);

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for brush_stroke_canvas_painter: directed and random pointer, stamp and read
// transactions, with every result checked against a mirror of the canvas kept here.
// Depends on bpc_pkg and the design files.
module testbench;

   localparam int CANVAS_W = bpc_pkg::DEF_CANVAS_WIDTH;
   localparam int CANVAS_H = bpc_pkg::DEF_CANVAS_HEIGHT;
   localparam int PIXELS = CANVAS_W * CANVAS_H;
   localparam int IDX_W = $clog2(PIXELS);
   localparam int TYPE_W = bpc_pkg::TYPE_W;
   localparam int COORD_W = bpc_pkg::COORD_W;
   localparam int RADDR_W = bpc_pkg::RADDR_W;
   localparam int VALUE_W = bpc_pkg::VALUE_W;
   localparam logic [TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_SPARE_LAST = 3'd7;
   localparam int STALL_LIMIT = 100000;
   localparam int RANDOM_ITEMS = 1525;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_W = $clog2(RANDOM_PHASES);

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               was_read;
   } reply_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [TYPE_W-1:0]         req_type;
   logic signed [COORD_W-1:0] req_pos_x;
   logic signed [COORD_W-1:0] req_pos_y;
   logic [RADDR_W-1:0]        req_read_addr;
   logic                      rsp_strobe;
   logic [VALUE_W-1:0]        rsp_read_value;
   logic                      rsp_was_read;
   logic                      csr_wr_en;
   logic [VALUE_W-1:0]        csr_wr_data;

   logic [VALUE_W-1:0] canvas_mirror [PIXELS];
   logic [VALUE_W-1:0] ink_mirror;
   int                 pen_x;
   int                 pen_y;
   reply_type          expected_replies [$];
   int                 events_sent = 0;
   int                 burst_left = 0;
   int                 mismatches = 0;
   int                 stall_cycles = 0;

   brush_stroke_canvas_painter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_read_addr  (req_read_addr),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_was_read   (rsp_was_read),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void paint_brush(int cx, int cy);
      int px;
      int py;
      for (int oy = -1; oy <= 1; oy++) begin
         for (int ox = -1; ox <= 1; ox++) begin
            px = cx + ox;
            py = cy + oy;
            if (px >= 0 && px < CANVAS_W && py >= 0 && py < CANVAS_H)
               canvas_mirror[IDX_W'(py * CANVAS_W + px)] = ink_mirror;
         end
      end
   endfunction

   function automatic void paint_stroke(int x0, int y0, int x1, int y1);
      int dx;
      int dy;
      int steps;
      dx = x1 - x0;
      dy = y1 - y0;
      steps = (dx < 0) ? -dx : dx;
      if (dy > steps || -dy > steps)
         steps = (dy < 0) ? -dy : dy;
      if (steps == 0)
         paint_brush(x1, y1);
      else
         for (int i = 0; i <= steps; i++)
            paint_brush(x0 + dx * i / steps, y0 + dy * i / steps);
   endfunction

   function automatic reply_type apply_event(logic [TYPE_W-1:0] kind, int x, int y,
                                             int addr);
      reply_type r;
      r.value = '0;
      r.was_read = 1'b0;
      case (kind)
         bpc_pkg::REQ_DOWN: begin
            paint_brush(x, y);
            pen_x = x;
            pen_y = y;
         end
         bpc_pkg::REQ_MOVE: begin
            paint_stroke(pen_x, pen_y, x, y);
            pen_x = x;
            pen_y = y;
         end
         bpc_pkg::REQ_UP: begin
            pen_x = -1;
            pen_y = -1;
         end
         bpc_pkg::REQ_HOLD: begin
            paint_brush(x, y);
         end
         bpc_pkg::REQ_READ: begin
            r.was_read = 1'b1;
            if (addr < PIXELS)
               r.value = canvas_mirror[IDX_W'(addr)];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic int pick_coord(int limit, int centre, int wild_odds);
      int c;
      if ($urandom_range(1, wild_odds) == 1)
         return int'($urandom_range(0, 2047)) - 1024;
      if ($urandom_range(0, 1) == 1) begin
         c = centre + int'($urandom_range(0, 40)) - 20;
         if (c < -1024)
            c = -1024;
         if (c > 1023)
            c = 1023;
         return c;
      end
      return int'($urandom_range(0, limit + 11)) - 6;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_event(input logic [TYPE_W-1:0] kind, input int x, input int y,
                             input int addr);
      logic signed [COORD_W-1:0] x_bits;
      logic signed [COORD_W-1:0] y_bits;
      logic [RADDR_W-1:0]        addr_bits;
      x_bits = COORD_W'(x);
      y_bits = COORD_W'(y);
      addr_bits = RADDR_W'(addr);
      pace_sender();
      req_type <= kind;
      req_pos_x <= x_bits;
      req_pos_y <= y_bits;
      req_read_addr <= addr_bits;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_replies.push_back(apply_event(kind, int'(x_bits), int'(y_bits),
                                             int'(addr_bits)));
      events_sent++;
   endtask

   task automatic send_read();
      int spot;
      if ($urandom_range(0, 15) == 0)
         spot = $urandom_range(0, 8191);
      else if (pen_x >= 0 && pen_x < CANVAS_W && pen_y >= 0 && pen_y < CANVAS_H &&
               $urandom_range(0, 1) == 1)
         spot = pen_y * CANVAS_W + pen_x + int'($urandom_range(0, 2)) - 1 +
                (int'($urandom_range(0, 2)) - 1) * CANVAS_W;
      else
         spot = $urandom_range(0, PIXELS - 1);
      if (spot < 0)
         spot = 0;
      send_event(bpc_pkg::REQ_READ, $urandom, $urandom, spot);
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      wait (expected_replies.size() == 0);
      @(posedge clock);
   endtask

   task automatic write_ink(input logic [VALUE_W-1:0] colour);
      while (busy) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= colour;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ink_mirror = colour;
   endtask

   task automatic test_field_extremes();
      write_ink(32'hFFFF_FFFF);
      send_event(bpc_pkg::REQ_READ, 0, 0, 0);
      send_event(bpc_pkg::REQ_READ, 0, 0, PIXELS - 1);
      send_event(bpc_pkg::REQ_HOLD, -1024, -1024, 'h1FFF);
      send_event(bpc_pkg::REQ_HOLD, 1023, 1023, 0);
      send_event(bpc_pkg::REQ_DOWN, 0, 0, 0);
      send_event(bpc_pkg::REQ_UP, 0, 0, 0);
      send_event(bpc_pkg::REQ_HOLD, CANVAS_W - 1, CANVAS_H - 1, 0);
      send_event(bpc_pkg::REQ_HOLD, -1, 40, 0);
      send_event(bpc_pkg::REQ_READ, 0, 0, 0);
      send_event(bpc_pkg::REQ_READ, -1, -1, PIXELS - 1);
      send_event(bpc_pkg::REQ_READ, 0, 0, PIXELS);
      send_event(bpc_pkg::REQ_READ, 0, 0, 'h1FFF);
      drain_replies();
   endtask

   task automatic test_strokes();
      write_ink(32'h5A5A_A5A5);
      // With no press since the last up the stroke starts from the corner outside.
      send_event(bpc_pkg::REQ_MOVE, 4, 3, 0);
      send_event(bpc_pkg::REQ_DOWN, 10, 10, 0);
      send_event(bpc_pkg::REQ_MOVE, 10, 10, 0);
      send_event(bpc_pkg::REQ_MOVE, 30, 17, 0);
      send_event(bpc_pkg::REQ_MOVE, 17, 40, 0);
      send_event(bpc_pkg::REQ_UP, 0, 0, 0);
      send_event(bpc_pkg::REQ_READ, 0, 0, 40 * CANVAS_W + 17);
      send_event(bpc_pkg::REQ_DOWN, -1024, -1024, 0);
      send_event(bpc_pkg::REQ_MOVE, 1023, 1023, 0);
      send_event(bpc_pkg::REQ_UP, 0, 0, 0);
      drain_replies();
   endtask

   task automatic test_spare_codes();
      for (int c = int'(REQ_SPARE_FIRST); c <= int'(REQ_SPARE_LAST); c++)
         send_event(TYPE_W'(c), 20, 20, 20 * CANVAS_W + 20);
      send_event(bpc_pkg::REQ_READ, 0, 0, 20 * CANVAS_W + 20);
      drain_replies();
   endtask

   task automatic run_stroke();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3))
            send_event(TYPE_W'($urandom_range(0, 7)), pick_coord(CANVAS_W, pen_x, 8),
                       pick_coord(CANVAS_H, pen_y, 8), $urandom);
         return;
      end
      send_event(bpc_pkg::REQ_DOWN, pick_coord(CANVAS_W, pen_x, 8),
                 pick_coord(CANVAS_H, pen_y, 8), $urandom);
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 5))
            0: send_event(bpc_pkg::REQ_HOLD, pick_coord(CANVAS_W, pen_x, 8),
                          pick_coord(CANVAS_H, pen_y, 8), $urandom);
            1: send_read();
            default: send_event(bpc_pkg::REQ_MOVE, pick_coord(CANVAS_W, pen_x, 150),
                                pick_coord(CANVAS_H, pen_y, 150), $urandom);
         endcase
      end
      if ($urandom_range(0, 9) != 0)
         send_event(bpc_pkg::REQ_UP, $urandom, $urandom, $urandom);
      send_read();
   endtask

   task automatic test_random_strokes();
      logic [VALUE_W-1:0] inks [RANDOM_PHASES];
      int                 base;
      inks = '{$urandom(), 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
      base = events_sent;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_ink(inks[PHASE_W'(phase)]);
         while (events_sent < base + (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES)
            run_stroke();
         drain_replies();
      end
   endtask

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected result", rsp_read_value, '0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_read_value !== want.value)
               report_mismatch("read_value", rsp_read_value, want.value);
            if (rsp_was_read !== want.was_read)
               report_mismatch("was_read", VALUE_W'(rsp_was_read),
                               VALUE_W'(want.was_read));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((start && !busy) || rsp_strobe === 1'b1)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = bpc_pkg::REQ_DOWN;
      req_pos_x = '0;
      req_pos_y = '0;
      req_read_addr = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      canvas_mirror = '{default: '0};
      ink_mirror = '0;
      pen_x = -1;
      pen_y = -1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_strokes();
      test_spare_codes();
      test_random_strokes();
      drain_replies();
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
